[rtl/frt_pkg.sv]
`timescale 1ns / 1ps

package frt_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DFLT = 524288;
    localparam logic [31:0] IDR_HOLDOFF_RESET    = 32'd200000;

    localparam logic [1:0] FT_VIDEO = 2'd0;
    localparam logic [1:0] FT_AUDIO = 2'd1;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DONE      = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_WAIT_KEY  = 3'd3,
        ST_STALE     = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_OOB       = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  frame_type;
        logic        key_flag;
        logic [31:0] frame_seq;
        logic [63:0] frame_time;
        logic [31:0] frame_total;
        logic [31:0] frag_start;
        logic [31:0] frag_bytes;
        logic [63:0] now_us;
    } t_frag_in;

    typedef struct packed {
        t_status     status;
        logic        channel;
        logic [18:0] write_offset;
        logic [19:0] write_length;
        logic [31:0] done_seq;
        logic        done_key;
        logic [63:0] done_time;
        logic [19:0] done_length;
        logic        idr_request;
        logic [31:0] frames_ok;
        logic [31:0] frames_lost;
        logic [31:0] frames_incomplete;
    } t_frag_out;

endpackage

[rtl/fragment_reassembly_tracker.sv]
`timescale 1ns / 1ps

// Fragment reassembly tracker.
// The input channel (i_in_valid, o_in_stall, i_in) carries one fragment header per
// transaction. The output channel (o_out_valid, i_out_stall, o_out) returns exactly one
// result per accepted header: store location or drop reason, a completed frame report,
// the keyframe request flag and the video frame counters.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the minimum
// keyframe request spacing in microseconds; it is always ready. The user must write it
// only while no transaction is in flight; the block does not enforce this. A header is
// registered into the update stage and its result into the output register. Throughput
// is one transaction per cycle unless the receiver stalls: the context memory is read
// in the accept cycle, and the update stage modifies and writes the entry back when it
// advances, with the write forwarded into a read of the same channel in that cycle.
// Reset clears both contexts, the keyframe state, the counters and the output valid,
// and sets the spacing to 200000. When the receiver stalls, the result holds, the
// update stage keeps its transaction, and o_in_stall rises once both are occupied.
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_frag_in    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_frag_out   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned TOT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned RCV_W = TOT_W + 1;
    localparam logic [32:0] MAX_B = 33'(MAX_FRAME_BYTES);

    typedef struct packed {
        logic [31:0]      seq;
        logic             key;
        logic [63:0]      time_us;
        logic [TOT_W-1:0] total;
        logic [RCV_W-1:0] received;
        logic             active;
    } t_ctx;

    t_ctx        r_ctx_mem [2];
    logic [1:0]  r_ctx_vld;
    t_ctx        r_rd_ctx;

    logic        r_s1_valid;
    t_frag_in    r_s1;
    logic        r_s1_start0;
    logic [32:0] r_s1_end;
    logic        r_s1_oob;
    logic        r_s1_big;

    logic        r_out_valid;
    t_frag_out   r_out;

    logic [31:0] r_holdoff;
    logic [31:0] r_last_seq;
    logic        r_have_last;
    logic        r_waiting;
    logic [63:0] r_last_req;
    logic [31:0] r_ok;
    logic [31:0] r_lost;
    logic [31:0] r_incomplete;

    logic [31:0] n_last_seq;
    logic        n_have_last;
    logic        n_waiting;
    logic [63:0] n_last_req;
    logic [31:0] n_ok;
    logic [31:0] n_lost;
    logic [31:0] n_incomplete;

    logic        w_adv;
    logic        w_fire;
    logic        w_in_fire;
    logic [32:0] w_in_end;

    logic        w_live;
    logic        w_video;
    logic        w_ch;
    logic [31:0] w_expect;
    logic        w_gap;
    logic        w_abandon;
    logic [63:0] w_elapsed;
    logic        w_req;
    logic        w_wait_eff;
    logic        w_key_drop;
    logic        w_go0;
    logic        w_new;
    logic        w_stale;
    logic        w_load;
    logic        w_oob;
    logic        w_store;
    logic [RCV_W-1:0] w_rcv_sum;
    logic        w_done;
    t_ctx        w_cc;
    t_ctx        w_ctx_new;
    t_frag_out   w_res;
    logic        w_wr_en;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = r_s1_valid && w_adv;
    assign o_in_stall  = r_s1_valid && !w_adv;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_in_end    = {1'b0, i_in.frag_start} + {1'b0, i_in.frag_bytes};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        w_live     = (r_s1.frame_type == FT_VIDEO) || (r_s1.frame_type == FT_AUDIO);
        w_video    = (r_s1.frame_type == FT_VIDEO);
        w_ch       = r_s1.frame_type[0];
        w_expect   = r_last_seq + 32'd1;
        w_gap      = w_video && r_have_last && r_s1_start0 && (r_s1.frame_seq > w_expect);
        w_abandon  = w_video && r_rd_ctx.active && (r_s1.frame_seq != r_rd_ctx.seq) &&
                     (r_rd_ctx.received < {1'b0, r_rd_ctx.total});
        w_elapsed  = r_s1.now_us - r_last_req;
        w_req      = (w_gap || w_abandon) && (w_elapsed >= {32'd0, r_holdoff});
        w_wait_eff = r_waiting || w_req;
        w_key_drop = w_video && r_s1_start0 && w_wait_eff && !r_s1.key_flag;
        w_go0      = w_live && !w_key_drop;
        w_new      = w_go0 && (!r_rd_ctx.active || (r_rd_ctx.seq != r_s1.frame_seq));
        w_stale    = w_new && r_rd_ctx.active && (r_s1.frame_seq < r_rd_ctx.seq);
        w_load     = w_new && !w_stale;

        w_cc = r_rd_ctx;
        if (w_load) begin
            w_cc.key      = r_s1.key_flag;
            w_cc.seq      = r_s1.frame_seq;
            w_cc.time_us  = r_s1.frame_time;
            w_cc.total    = r_s1.frame_total[TOT_W-1:0];
            w_cc.received = '0;
            w_cc.active   = !r_s1_big;
        end

        w_oob     = r_s1_oob || (r_s1_end > 33'(w_cc.total));
        w_store   = w_go0 && !w_stale && !(w_load && r_s1_big) && !w_oob;
        w_rcv_sum = w_cc.received + RCV_W'(r_s1.frag_bytes[TOT_W-1:0]);
        w_done    = w_store && (w_rcv_sum >= {1'b0, w_cc.total});

        w_ctx_new = w_cc;
        if (w_store) begin
            w_ctx_new.received = w_rcv_sum;
            if (r_s1_start0) begin
                w_ctx_new.key = r_s1.key_flag;
            end
        end
        if (w_done) begin
            w_ctx_new.active   = 1'b0;
            w_ctx_new.received = '0;
        end

        n_lost       = r_lost + (w_gap ? (r_s1.frame_seq - w_expect) : 32'd0);
        n_incomplete = r_incomplete + {31'd0, w_abandon};
        n_ok         = r_ok + {31'd0, w_done && w_video};
        n_last_seq   = (w_video && r_s1_start0) ? r_s1.frame_seq : r_last_seq;
        n_have_last  = r_have_last || (w_video && r_s1_start0);
        n_waiting    = (w_video && r_s1_start0 && w_wait_eff) ? !r_s1.key_flag : w_wait_eff;
        n_last_req   = w_req ? r_s1.now_us : r_last_req;

        w_res                   = '0;
        w_res.status            = ST_IGNORED;
        w_res.idr_request       = w_req;
        w_res.frames_ok         = n_ok;
        w_res.frames_lost       = n_lost;
        w_res.frames_incomplete = n_incomplete;
        if (w_live) begin
            w_res.channel = w_ch;
            if (w_key_drop) begin
                w_res.status = ST_WAIT_KEY;
            end else if (w_stale) begin
                w_res.status = ST_STALE;
            end else if (w_load && r_s1_big) begin
                w_res.status = ST_TOO_LARGE;
            end else if (w_oob) begin
                w_res.status = ST_OOB;
            end else begin
                w_res.status       = w_done ? ST_DONE : ST_STORED;
                w_res.write_offset = r_s1.frag_start[18:0];
                w_res.write_length = r_s1.frag_bytes[19:0];
                if (w_done) begin
                    w_res.done_seq    = w_ctx_new.seq;
                    w_res.done_key    = w_ctx_new.key;
                    w_res.done_time   = w_ctx_new.time_us;
                    w_res.done_length = 20'(w_cc.total);
                end
            end
        end

        w_wr_en = w_fire && w_live;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ctx_mem[w_ch] <= w_ctx_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            if (w_wr_en && (w_ch == i_in.frame_type[0])) begin
                r_rd_ctx <= w_ctx_new;
            end else if (r_ctx_vld[i_in.frame_type[0]]) begin
                r_rd_ctx <= r_ctx_mem[i_in.frame_type[0]];
            end else begin
                r_rd_ctx <= '0;
            end
            r_s1        <= i_in;
            r_s1_start0 <= (i_in.frag_start == 32'd0);
            r_s1_end    <= w_in_end;
            r_s1_oob    <= ({1'b0, i_in.frag_start} >= MAX_B) || (w_in_end > MAX_B);
            r_s1_big    <= ({1'b0, i_in.frame_total} > MAX_B);
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_vld    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_holdoff    <= IDR_HOLDOFF_RESET;
            r_last_seq   <= '0;
            r_have_last  <= 1'b0;
            r_waiting    <= 1'b0;
            r_last_req   <= '0;
            r_ok         <= '0;
            r_lost       <= '0;
            r_incomplete <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_holdoff <= i_cfg_data;
            end
            if (w_wr_en) begin
                r_ctx_vld[w_ch] <= 1'b1;
            end
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_fire) begin
                r_last_seq   <= n_last_seq;
                r_have_last  <= n_have_last;
                r_waiting    <= n_waiting;
                r_last_req   <= n_last_req;
                r_ok         <= n_ok;
                r_lost       <= n_lost;
                r_incomplete <= n_incomplete;
            end
        end
    end

    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("Input stalled without a held transaction.");

    a_ok_counts_video_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_res.status == ST_DONE) && (w_res.channel == 1'b0))
        |=> (r_ok == $past(r_ok) + 32'd1))
        else $error("Completed video frame not counted.");

    a_ignored_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_live) |=> ((r_waiting == $past(r_waiting)) &&
        (r_last_req == $past(r_last_req)) && !r_out.idr_request))
        else $error("Ignored transaction changed keyframe state.");

endmodule

[tb/tb_fragment_reassembly_tracker.sv]
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker
    import frt_pkg::*;
;

    localparam int unsigned FRAME_LIMIT = MAX_FRAME_BYTES_DFLT;
    localparam logic [1:0] FT_IDR_REQ = 2'd2;
    localparam logic [1:0] FT_OTHER   = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_frag_in    i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_frag_out   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    fragment_reassembly_tracker #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tracker state mirrored from the header stream.
    logic [31:0] holdoff_us = IDR_HOLDOFF_RESET;
    logic [31:0] trk_seq [2] = '{default: '0};
    logic        trk_key [2] = '{default: '0};
    logic [63:0] trk_time [2] = '{default: '0};
    logic [31:0] trk_total [2] = '{default: '0};
    logic [31:0] trk_recv [2] = '{default: '0};
    logic        trk_open [2] = '{default: '0};
    logic [31:0] prev_video_seq = '0;
    logic        seen_video_seq = 1'b0;
    logic        key_wait = 1'b0;
    logic [63:0] last_req_us = '0;
    logic [31:0] ok_cnt = '0;
    logic [31:0] lost_cnt = '0;
    logic [31:0] incomplete_cnt = '0;

    t_frag_in    header_queue [$];
    t_frag_out   due_verdicts [$];
    logic        in_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned fail_count = 0;
    int unsigned frag_count = 0;
    logic [63:0] clock_us = '0;
    logic [31:0] video_seq = '0;
    logic [31:0] audio_seq = '0;

    function automatic bit send_request(logic [63:0] now);
        if (now - last_req_us < {32'd0, holdoff_us}) return 1'b0;
        last_req_us = now;
        key_wait = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_frag_out track_fragment(t_frag_in f);
        t_frag_out   r;
        logic        go;
        logic [31:0] next_seq;
        logic [32:0] tail_pos;
        int unsigned ch;
        r = '0;
        r.status = ST_IGNORED;
        if (f.frame_type == FT_VIDEO || f.frame_type == FT_AUDIO) begin
            ch = (f.frame_type == FT_AUDIO) ? 1 : 0;
            r.channel = (ch == 1);
            go = 1'b1;
            if (f.frame_type == FT_VIDEO) begin
                if (seen_video_seq && f.frag_start == 0) begin
                    next_seq = prev_video_seq + 32'd1;
                    if (f.frame_seq > next_seq) begin
                        lost_cnt += f.frame_seq - next_seq;
                        if (send_request(f.now_us)) r.idr_request = 1'b1;
                    end
                end
                if (trk_open[0] && f.frame_seq != trk_seq[0] && trk_recv[0] < trk_total[0]) begin
                    incomplete_cnt++;
                    if (send_request(f.now_us)) r.idr_request = 1'b1;
                end
                if (f.frag_start == 0) begin
                    prev_video_seq = f.frame_seq;
                    seen_video_seq = 1'b1;
                end
                if (key_wait && f.frag_start == 0) begin
                    if (f.key_flag) begin
                        key_wait = 1'b0;
                    end else begin
                        r.status = ST_WAIT_KEY;
                        go = 1'b0;
                    end
                end
            end
            if (go && (!trk_open[ch] || trk_seq[ch] != f.frame_seq)) begin
                if (trk_open[ch] && f.frame_seq < trk_seq[ch]) begin
                    r.status = ST_STALE;
                    go = 1'b0;
                end else begin
                    trk_key[ch] = f.key_flag;
                    trk_seq[ch] = f.frame_seq;
                    trk_time[ch] = f.frame_time;
                    trk_total[ch] = f.frame_total;
                    trk_recv[ch] = '0;
                    trk_open[ch] = 1'b1;
                    if (f.frame_total > FRAME_LIMIT) begin
                        trk_open[ch] = 1'b0;
                        r.status = ST_TOO_LARGE;
                        go = 1'b0;
                    end
                end
            end
            if (go) begin
                tail_pos = {1'b0, f.frag_start} + {1'b0, f.frag_bytes};
                if (f.frag_start >= FRAME_LIMIT || tail_pos > FRAME_LIMIT ||
                    tail_pos > {1'b0, trk_total[ch]}) begin
                    r.status = ST_OOB;
                end else begin
                    r.status = ST_STORED;
                    r.write_offset = f.frag_start[18:0];
                    r.write_length = f.frag_bytes[19:0];
                    trk_recv[ch] += f.frag_bytes;
                    if (f.frag_start == 0) trk_key[ch] = f.key_flag;
                    if (trk_recv[ch] >= trk_total[ch]) begin
                        r.status = ST_DONE;
                        if (ch == 0) ok_cnt++;
                        r.done_seq = trk_seq[ch];
                        r.done_key = trk_key[ch];
                        r.done_time = trk_time[ch];
                        r.done_length = trk_total[ch][19:0];
                        trk_open[ch] = 1'b0;
                        trk_recv[ch] = '0;
                    end
                end
            end
        end
        r.frames_ok = ok_cnt;
        r.frames_lost = lost_cnt;
        r.frames_incomplete = incomplete_cnt;
        return r;
    endfunction

    function automatic string field_diffs(t_frag_out want, t_frag_out got);
        string s;
        s = "";
        if (got.status !== want.status)
            s = {s, $sformatf(" status exp %0d act %0d", want.status, got.status)};
        if (got.channel !== want.channel)
            s = {s, $sformatf(" channel exp %0d act %0d", want.channel, got.channel)};
        if (got.write_offset !== want.write_offset)
            s = {s, $sformatf(" write_offset exp %h act %h", want.write_offset, got.write_offset)};
        if (got.write_length !== want.write_length)
            s = {s, $sformatf(" write_length exp %h act %h", want.write_length, got.write_length)};
        if (got.done_seq !== want.done_seq)
            s = {s, $sformatf(" done_seq exp %h act %h", want.done_seq, got.done_seq)};
        if (got.done_key !== want.done_key)
            s = {s, $sformatf(" done_key exp %0d act %0d", want.done_key, got.done_key)};
        if (got.done_time !== want.done_time)
            s = {s, $sformatf(" done_time exp %h act %h", want.done_time, got.done_time)};
        if (got.done_length !== want.done_length)
            s = {s, $sformatf(" done_length exp %h act %h", want.done_length, got.done_length)};
        if (got.idr_request !== want.idr_request)
            s = {s, $sformatf(" idr_request exp %0d act %0d", want.idr_request, got.idr_request)};
        if (got.frames_ok !== want.frames_ok)
            s = {s, $sformatf(" frames_ok exp %h act %h", want.frames_ok, got.frames_ok)};
        if (got.frames_lost !== want.frames_lost)
            s = {s, $sformatf(" frames_lost exp %h act %h", want.frames_lost, got.frames_lost)};
        if (got.frames_incomplete !== want.frames_incomplete)
            s = {s, $sformatf(" frames_incomplete exp %h act %h",
                              want.frames_incomplete, got.frames_incomplete)};
        return s;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_frag_out want;
        string     diffs;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) due_verdicts.push_back(track_fragment(i_in));
            if (o_out_valid && !i_out_stall) begin
                if (due_verdicts.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result transaction: %h", o_out);
                    fail_count++;
                end else begin
                    want = due_verdicts.pop_front();
                    diffs = field_diffs(want, o_out);
                    if (diffs != "") begin
                        if (fail_count < 10) $display("result mismatch:%s", diffs);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (header_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in <= header_queue.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 1) == 0);
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 9) < 8);
            end
        endcase
    end

    function automatic logic [63:0] next_now();
        case ($urandom_range(0, 19))
            0: begin
                clock_us = {$urandom, $urandom};
            end
            1: begin
                clock_us += 64'd4294967296 + 64'($urandom);
            end
            2, 3: begin
                clock_us += 64'($urandom_range(100000, 400000));
            end
            default: begin
                clock_us += 64'($urandom_range(0, 3000));
            end
        endcase
        return clock_us;
    endfunction

    function automatic logic [31:0] pick_total();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3000);
        if (r < 90) return $urandom_range(3001, 60000);
        if (r < 98) return $urandom_range(60001, FRAME_LIMIT);
        return FRAME_LIMIT;
    endfunction

    task automatic add_frag(logic [1:0] ftype, logic key, logic [31:0] seq, logic [63:0] ftime,
                            logic [31:0] total, logic [31:0] start, logic [31:0] nbytes,
                            logic [63:0] now);
        t_frag_in h;
        h.frame_type = ftype;
        h.key_flag = key;
        h.frame_seq = seq;
        h.frame_time = ftime;
        h.frame_total = total;
        h.frag_start = start;
        h.frag_bytes = nbytes;
        h.now_us = now;
        header_queue.push_back(h);
        if (ftype == FT_VIDEO || ftype == FT_AUDIO) frag_count++;
    endtask

    task automatic add_frame(logic [1:0] ftype, logic [31:0] seq, logic key, logic [31:0] total);
        logic [31:0] offs [$];
        logic [31:0] lens [$];
        logic [63:0] ftime;
        logic [31:0] pos;
        logic [31:0] len;
        logic [31:0] tmp;
        int unsigned twist;
        int          n;
        int          i;
        ftime = {$urandom, $urandom};
        pos = '0;
        do begin
            if (offs.size() == 3 || total - pos < 2) len = total - pos;
            else len = $urandom_range(1, total - pos);
            offs.push_back(pos);
            lens.push_back(len);
            pos += len;
        end while (pos < total);
        twist = $urandom_range(0, 19);
        n = offs.size();
        if (twist < 3 && n > 1) begin
            void'(offs.pop_back());
            void'(lens.pop_back());
        end else if (twist < 5 && n > 2) begin
            tmp = offs[n-1]; offs[n-1] = offs[n-2]; offs[n-2] = tmp;
            tmp = lens[n-1]; lens[n-1] = lens[n-2]; lens[n-2] = tmp;
        end
        n = offs.size();
        for (i = 0; i < n; i++) begin
            if (twist == 6 && i > 0 && i == n - 1)
                add_frag(ftype, 1'b0, seq - 32'($urandom_range(1, 3)), ftime, total,
                         offs[i], lens[i], next_now());
            add_frag(ftype, key, seq, ftime, total, offs[i], lens[i], next_now());
            if (twist == 5 && i == 0)
                add_frag(ftype, key, seq, ftime, total, offs[i], lens[i], next_now());
        end
    endtask

    task automatic add_noise();
        logic [1:0] ft;
        ft = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
            add_frag(ft, 1'($urandom), $urandom, {$urandom, $urandom}, $urandom, $urandom,
                     $urandom, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : next_now());
        else
            add_frag(ft, 1'($urandom), video_seq + $urandom_range(0, 4) - 32'd2,
                     {$urandom, $urandom}, $urandom_range(0, 4000), $urandom_range(0, 3000),
                     $urandom_range(0, 3000), next_now());
    endtask

    task automatic run_random(int unsigned target);
        int unsigned pick;
        int unsigned stop;
        logic [31:0] seq;
        logic [31:0] total;
        stop = frag_count + target;
        while (frag_count < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 9))
                    7: begin
                        seq = video_seq + $urandom_range(2, 6);
                    end
                    8: begin
                        seq = video_seq - $urandom_range(0, 2);
                    end
                    9: begin
                        seq = $urandom;
                    end
                    default: begin
                        seq = video_seq + 32'd1;
                    end
                endcase
                video_seq = seq;
                add_frame(FT_VIDEO, seq, ($urandom_range(0, 2) == 0), pick_total());
            end else if (pick < 80) begin
                if ($urandom_range(0, 7) == 0) audio_seq = audio_seq - $urandom_range(0, 2);
                else audio_seq = audio_seq + 32'd1;
                add_frame(FT_AUDIO, audio_seq, 1'($urandom), pick_total());
            end else if (pick < 92) begin
                add_noise();
            end else begin
                total = ($urandom_range(0, 1) == 0) ? FRAME_LIMIT + 1 + $urandom_range(0, 1000)
                                                    : ($urandom | 32'h8000_0000);
                if ($urandom_range(0, 1) == 0) begin
                    video_seq = video_seq + 32'd1;
                    add_frag(FT_VIDEO, 1'($urandom), video_seq, {$urandom, $urandom}, total,
                             32'd0, $urandom_range(0, 2000), next_now());
                end else begin
                    audio_seq = audio_seq + 32'd1;
                    add_frag(FT_AUDIO, 1'($urandom), audio_seq, {$urandom, $urandom}, total,
                             32'd0, $urandom_range(0, 2000), next_now());
                end
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (header_queue.size() != 0 || i_in_valid || due_verdicts.size() != 0);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_holdoff(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        holdoff_us = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_frag(FT_IDR_REQ, 1'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                 $urandom, $urandom, 64'd0);
        add_frag(FT_OTHER, 1'b1, '1, '1, '1, '1, '1, '1);
        add_frag(FT_VIDEO, 1'b1, 32'd10, 64'd1000, 32'd100, 32'd0, 32'd40, 64'd10);
        add_frag(FT_VIDEO, 1'b0, 32'd10, 64'd1000, 32'd100, 32'd40, 32'd60, 64'd20);
        add_frag(FT_AUDIO, 1'b0, 32'd5, 64'd0, 32'd0, 32'd0, 32'd0, 64'd30);
        add_frag(FT_VIDEO, 1'b0, 32'd15, 64'd2000, 32'd100, 32'd0, 32'd50, 64'd300000);
        add_frag(FT_VIDEO, 1'b0, 32'd15, 64'd2000, 32'd100, 32'd50, 32'd10, 64'd300010);
        add_frag(FT_VIDEO, 1'b0, 32'd16, 64'd3000, 32'd100, 32'd0, 32'd100, 64'd300020);
        add_frag(FT_VIDEO, 1'b1, 32'd17, 64'd4000, FRAME_LIMIT, 32'd0, FRAME_LIMIT,
                 64'd300030);
        add_frag(FT_VIDEO, 1'b1, 32'd20, '1, 32'd1000, 32'd0, 32'd100, 64'd600000);
        add_frag(FT_VIDEO, 1'b0, 32'd19, 64'd5000, 32'd1000, 32'd100, 32'd10, 64'd600010);
        add_frag(FT_VIDEO, 1'b0, 32'd20, '1, 32'd1000, '1, '1, 64'd600015);
        add_frag(FT_VIDEO, 1'b0, 32'd20, '1, 32'd1000, 32'd900, 32'd200, 64'd600020);
        add_frag(FT_VIDEO, 1'b1, 32'd21, 64'd6000, 32'd600000, 32'd0, 32'd10, 64'd600030);
        add_frag(FT_AUDIO, 1'b0, 32'd7, 64'd7000, FRAME_LIMIT + 1, 32'd0, 32'd1, 64'd600031);
        add_frag(FT_AUDIO, 1'b0, 32'd8, 64'd8000, 32'd2000, FRAME_LIMIT, 32'd0, 64'd600032);
        add_frag(FT_AUDIO, 1'b0, 32'd8, 64'd8000, 32'd2000, 32'd1000, 32'd1000, 64'd600033);
        add_frag(FT_AUDIO, 1'b1, 32'd8, 64'd8000, 32'd2000, 32'd0, 32'd1000, 64'd600034);
        add_frag(FT_VIDEO, 1'b1, '1, '1, 32'd10, 32'd0, 32'd10, 64'd600040);
        add_frag(FT_VIDEO, 1'b1, 32'd0, 64'd0, 32'd5, 32'd0, 32'd5, '1);
        add_frag(FT_VIDEO, 1'b0, 32'd5, 64'd9000, 32'd50, 32'd0, 32'd50, 64'd0);
        add_frag(FT_VIDEO, 1'b1, 32'd6, 64'd9100, 32'd0, 32'd0, 32'd0, 64'd10);
        add_frag(FT_VIDEO, 1'b1, 32'd7, 64'd9200, FRAME_LIMIT, FRAME_LIMIT - 1, 32'd1, 64'd20);
        add_frag(FT_VIDEO, 1'b1, 32'd7, 64'd9200, FRAME_LIMIT, 32'd0, FRAME_LIMIT - 1, 64'd30);
        video_seq = 32'd7;
        audio_seq = 32'd8;
        clock_us = 64'd100;
        wait_idle();

        write_holdoff(32'd0);
        run_random(200);
        wait_idle();
        write_holdoff(32'hFFFF_FFFF);
        run_random(150);
        wait_idle();
        write_holdoff(32'($urandom_range(1, 300000)));
        run_random(150);
        wait_idle();
        write_holdoff(IDR_HOLDOFF_RESET);
        run_random(100);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && due_verdicts.size() == 0) begin
            $display("tb_fragment_reassembly_tracker: PASS");
        end else begin
            $display("tb_fragment_reassembly_tracker: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb_fragment_reassembly_tracker: FAIL");
        $finish;
    end

endmodule
